@@ src/uvad_pkg.sv @@
package uvad_pkg;

  // Width of the value port and number of digit cells in the chain.
  localparam int VALUE_W            = 32;
  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int NUM_CELLS          = 10;
  localparam int DIGIT_W            = 4;
  localparam int KIND_W             = 2;
  localparam int CHAR_W             = 7;

  // Format kinds. Any kind other than decimal selects hex, and bit 1 selects upper case.
  localparam logic [KIND_W-1:0] KIND_DEC       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEX_LOWER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEX_UPPER = 2'd2;
  localparam int                KIND_UPPER_BIT = 1;

  // ASCII offsets for digits, upper-case letters and lower-case letters.
  localparam logic [CHAR_W-1:0] ASCII_ZERO      = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_OFS = 7'd55;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_OFS = 7'd87;

  localparam logic [DIGIT_W-1:0] DEC_MAX_DIGIT  = 4'd9;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT   = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJUST  = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } uvad_state_t;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;   // load zero into every digit
    logic conv;    // take two bits from the lower neighbor
    logic shift;   // take the whole digit from the lower neighbor
    logic dec;     // apply the decimal add-3 correction
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                       input logic [KIND_W-1:0]  kind);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d <= DEC_MAX_DIGIT) begin
      return ext + ASCII_ZERO;
    end else if (kind[KIND_UPPER_BIT]) begin
      return ext + ASCII_UPPER_OFS;
    end else begin
      return ext + ASCII_LOWER_OFS;
    end
  endfunction

endpackage

@@ src/uvad_digit_cell.sv @@
module uvad_digit_cell (
  input  logic                    clk,
  input  uvad_pkg::cell_ctl_t     ctl,
  input  logic                    cy1_i,
  input  logic                    cy2_i,
  input  logic [uvad_pkg::DIGIT_W-1:0] digit_i,
  output logic                    cy1_o,
  output logic                    cy2_o,
  output logic [uvad_pkg::DIGIT_W-1:0] digit_o
);
  import uvad_pkg::*;

  logic [DIGIT_W-1:0] dig_r;
  logic [DIGIT_W-1:0] dig_nxt;
  logic [DIGIT_W-1:0] c1;
  logic [DIGIT_W-1:0] mid;
  logic [DIGIT_W-1:0] c2;

  // Two shift-and-correct steps per cycle. In hex mode the correction is off
  // and the cell is a plain four-bit shift stage.
  always_comb begin
    c1  = (ctl.dec && (dig_r >= DABBLE_LIMIT)) ? dig_r + DABBLE_ADJUST : dig_r;
    mid = {c1[DIGIT_W-2:0], cy1_i};
    c2  = (ctl.dec && (mid >= DABBLE_LIMIT)) ? mid + DABBLE_ADJUST : mid;
  end

  assign cy1_o   = c1[DIGIT_W-1];
  assign cy2_o   = c2[DIGIT_W-1];
  assign digit_o = dig_r;

  always_comb begin
    if (ctl.clear) begin
      dig_nxt = '0;
    end else if (ctl.conv) begin
      dig_nxt = {c2[DIGIT_W-2:0], cy2_i};
    end else if (ctl.shift) begin
      dig_nxt = digit_i;
    end else begin
      dig_nxt = dig_r;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

endmodule

@@ src/unsigned_to_ascii_digits_unit.sv @@
// After the accepting edge the value is shifted into the digit chain two bits per
// conversion cycle, then an emit pass steps through the ten digit positions of the chain.
// A new word is accepted only in idle: busy stays high through the conversion and the
// emit pass, so the next word waits until the last digit position has gone out.
// Reset: synchronous, active low; returns to idle with no strobe pending.
// Results cannot be stalled: each character is shown for exactly one cycle.
module unsigned_to_ascii_digits_unit #(
  parameter int VALUE_BITS = uvad_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [uvad_pkg::VALUE_W-1:0]   in_value,
  input  logic [uvad_pkg::KIND_W-1:0]    in_kind,
  output logic                           out_strobe,
  output logic [uvad_pkg::CHAR_W-1:0]    out_character,
  output logic                           out_last_char
);
  import uvad_pkg::*;

  // Only the low bits of the value take part; the shift register is padded to an
  // even width so that two bits leave it in every conversion cycle.
  localparam int EFF_W   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int SHIFT_W = EFF_W + (EFF_W % 2);
  localparam int STEPS   = SHIFT_W / 2;
  localparam int CNT_W   = $clog2(STEPS + 1);
  localparam int POS_W   = $clog2(NUM_CELLS + 1);
  localparam logic [CNT_W-1:0] STEPS_C = CNT_W'(STEPS);
  localparam logic [POS_W-1:0] CELLS_C = POS_W'(NUM_CELLS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

  uvad_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 seen_r, seen_nxt;
  logic [SHIFT_W-1:0]   sh_r, sh_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic                 last_r, last_nxt;

  cell_ctl_t            ctl;
  logic                 accept;
  logic                 emit_now;

  // Chain wiring: index 0 is the least significant digit, the top cell holds the
  // digit that goes out next during the emit pass.
  logic [NUM_CELLS:0]   cy1;
  logic [NUM_CELLS:0]   cy2;
  logic [DIGIT_W-1:0]   dig [NUM_CELLS+1];
  logic [DIGIT_W-1:0]   top_digit;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // The bits of the value enter the bottom cell most significant first.
  assign cy1[0] = sh_r[SHIFT_W-1];
  assign cy2[0] = sh_r[SHIFT_W-2];
  assign dig[0] = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    uvad_digit_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .cy1_i   (cy1[i]),
      .cy2_i   (cy2[i]),
      .digit_i (dig[i]),
      .cy1_o   (cy1[i+1]),
      .cy2_o   (cy2[i+1]),
      .digit_o (dig[i+1])
    );
  end

  assign top_digit = dig[NUM_CELLS];

  // Leading zero positions are passed over without a strobe. The final position
  // always goes out, which gives the single '0' for a zero value. The carries out
  // of the top cell are never needed: the chain is deep enough for the value.
  assign emit_now = (state_r == ST_EMIT) &&
                    (seen_r || (top_digit != '0) || (pos_r == POS_ONE));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_r == CNT_ONE) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pos_r == POS_ONE) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Chain control and datapath updates.
  always_comb begin
    ctl.clear  = 1'b0;
    ctl.conv   = 1'b0;
    ctl.shift  = 1'b0;
    ctl.dec    = (kind_r == KIND_DEC);
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    seen_nxt   = seen_r;
    sh_nxt     = sh_r;
    kind_nxt   = kind_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.clear = 1'b1;
          cnt_nxt   = STEPS_C;
          sh_nxt    = SHIFT_W'(in_value[EFF_W-1:0]);
          kind_nxt  = in_kind;
        end
      end
      ST_CONV: begin
        ctl.conv = 1'b1;
        sh_nxt   = sh_r << 2;
        cnt_nxt  = cnt_r - CNT_ONE;
        if (cnt_r == CNT_ONE) begin
          pos_nxt  = CELLS_C;
          seen_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        ctl.shift  = 1'b1;
        pos_nxt    = pos_r - POS_ONE;
        seen_nxt   = seen_r || emit_now;
        strobe_nxt = emit_now;
        char_nxt   = digit_to_ascii(top_digit, kind_r);
        last_nxt   = (pos_r == POS_ONE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload and counters are qualified by the state and need no reset.
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    pos_r  <= pos_nxt;
    seen_r <= seen_nxt;
    sh_r   <= sh_nxt;
    kind_r <= kind_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_character = char_r;
  assign out_last_char = last_r;

endmodule

@@ src/uvad_port_checker.sv @@
module uvad_port_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_strobe,
  input logic [uvad_pkg::CHAR_W-1:0]  out_character,
  input logic                         out_last_char
);
  import uvad_pkg::*;

  // An accepted word keeps the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a word");

  // Every character is a decimal digit or a hex letter of either case.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_character >= ASCII_ZERO && out_character <= ASCII_ZERO + 7'd9) ||
                    (out_character >= 7'd65 && out_character <= 7'd70) ||
                    (out_character >= 7'd97 && out_character <= 7'd102)))
    else $error("character outside the digit set");

  // Once a number has begun, its characters follow in consecutive cycles.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_char) |=> out_strobe)
    else $error("gap inside a number");

  // While more characters are owed, no new word can be taken.
  a_busy_midway: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_char) |-> busy)
    else $error("unit idle with characters still owed");

  // An idle unit has no character on its way in the next cycle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_strobe)
    else $error("character appeared from an idle unit");

endmodule

bind unsigned_to_ascii_digits_unit uvad_port_checker u_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_character (out_character),
  .out_last_char (out_last_char)
);
